### design/agps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// agps_pkg
// Shared constants, types and the letter prime table for the prime-signature
// anagram grouper.
// ----------------------------------------------------------------------------
package agps_pkg;

  localparam int unsigned KEY_WIDTH_DEF   = 32;
  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned LETTER_W        = 5;
  localparam int unsigned GROUP_INDEX_W   = 6;
  localparam int unsigned PRIME_W         = 7;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [PRIME_W-1:0]  prime_t;

  // search word travelling down the cell row
  typedef struct packed {
    logic vld;
    logic found;
    logic is_new;
  } tok_ctrl_t;

  // first 26 primes; codes beyond z give a factor of one
  function automatic prime_t letter_prime(input letter_t code);
    prime_t p;
    p = prime_t'(1);
    case (code)
      5'd0:  p = prime_t'(2);
      5'd1:  p = prime_t'(3);
      5'd2:  p = prime_t'(5);
      5'd3:  p = prime_t'(7);
      5'd4:  p = prime_t'(11);
      5'd5:  p = prime_t'(13);
      5'd6:  p = prime_t'(17);
      5'd7:  p = prime_t'(19);
      5'd8:  p = prime_t'(23);
      5'd9:  p = prime_t'(29);
      5'd10: p = prime_t'(31);
      5'd11: p = prime_t'(37);
      5'd12: p = prime_t'(41);
      5'd13: p = prime_t'(43);
      5'd14: p = prime_t'(47);
      5'd15: p = prime_t'(53);
      5'd16: p = prime_t'(59);
      5'd17: p = prime_t'(61);
      5'd18: p = prime_t'(67);
      5'd19: p = prime_t'(71);
      5'd20: p = prime_t'(73);
      5'd21: p = prime_t'(79);
      5'd22: p = prime_t'(83);
      5'd23: p = prime_t'(89);
      5'd24: p = prime_t'(97);
      5'd25: p = prime_t'(101);
      default: p = prime_t'(1);
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

### design/agps_sig_acc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// agps_sig_acc
// Running prime-product signature; wraps modulo 2^KEY_WIDTH and returns to
// one after each word end.
// ----------------------------------------------------------------------------
module agps_sig_acc #(
  parameter int unsigned KEY_WIDTH = agps_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    accept_i,
  input  wire agps_pkg::letter_t       letter_i,
  input  wire logic                    no_letter_i,
  input  wire logic                    last_i,
  output logic     [KEY_WIDTH-1:0]     key_o
);

  logic [KEY_WIDTH-1:0] sig_q, sig_d;
  logic [KEY_WIDTH-1:0] factor;

  always_comb begin
    if (no_letter_i) begin
      factor = KEY_WIDTH'(1);
    end else begin
      factor = KEY_WIDTH'(agps_pkg::letter_prime(letter_i));
    end
  end

  assign key_o = sig_q * factor;

  always_comb begin
    sig_d = sig_q;
    if (accept_i) begin
      sig_d = last_i ? KEY_WIDTH'(1) : key_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q <= KEY_WIDTH'(1);
    end else begin
      sig_q <= sig_d;
    end
  end

endmodule
`default_nettype wire

### design/agps_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// agps_cell
// One table entry: compare the passing signature, store it at the first free
// place, hand the search word on to the next cell.
// ----------------------------------------------------------------------------
module agps_cell #(
  parameter int unsigned KEY_WIDTH = agps_pkg::KEY_WIDTH_DEF,
  parameter int unsigned IDX_W     = 6,
  parameter int unsigned CNT_W     = 7,
  parameter int unsigned CELL_IDX  = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire agps_pkg::tok_ctrl_t   ctrl_i,
  input  wire logic [KEY_WIDTH-1:0]  key_i,
  input  wire logic [IDX_W-1:0]      idx_i,
  input  wire logic [CNT_W-1:0]      count_i,
  output agps_pkg::tok_ctrl_t        ctrl_o,
  output logic      [KEY_WIDTH-1:0]  key_o,
  output logic      [IDX_W-1:0]      idx_o
);

  localparam logic [CNT_W-1:0] MyPos = CNT_W'(CELL_IDX);
  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic [KEY_WIDTH-1:0] entry_q;
  logic                 searching;
  logic                 hit;
  logic                 store;
  agps_pkg::tok_ctrl_t  ctrl_q, ctrl_d;
  logic [KEY_WIDTH-1:0] key_q;
  logic [IDX_W-1:0]     idx_q, idx_d;

  assign searching = ctrl_i.vld && !ctrl_i.found;
  assign hit       = searching && (MyPos < count_i) && (entry_q == key_i);
  assign store     = searching && (MyPos == count_i);

  always_comb begin
    ctrl_d = ctrl_i;
    idx_d  = idx_i;
    if (hit || store) begin
      ctrl_d.found  = 1'b1;
      ctrl_d.is_new = store;
      idx_d         = MyIdx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      entry_q <= key_i;
    end
    key_q <= key_i;
    idx_q <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign key_o  = key_q;
  assign idx_o  = idx_q;

endmodule
`default_nettype wire

### design/anagram_group_prime_signature_core.sv
`default_nettype none
// A letter without word end only updates the signature and gives no result.
// A word end's signature is registered, then passes every cell register of the row to its result.
// Throughput: one letter a cycle; a word end holds busy_o until its result cycle,
// as the search word walks the row of TABLE_DEPTH cells, one cell a cycle.
// Reset: asynchronous, active low; empties the table and sets the signature to 1.
// The receiver cannot stall: each result is shown for one cycle under result_valid_o.
// ----------------------------------------------------------------------------
// anagram_group_prime_signature_core
// Groups words by prime-product signature against a row of table cells.
// ----------------------------------------------------------------------------
module anagram_group_prime_signature_core #(
  parameter int unsigned TABLE_DEPTH = agps_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned KEY_WIDTH   = agps_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [agps_pkg::LETTER_W-1:0]       letter_i,
  input  wire logic                                no_letter_i,
  input  wire logic                                last_of_word_i,
  output logic                                     busy_o,
  output logic                                     result_valid_o,
  output logic      [agps_pkg::GROUP_INDEX_W-1:0]  group_index_o,
  output logic                                     new_group_o,
  output logic                                     table_full_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  logic                 accept;
  logic                 accept_last;
  logic [KEY_WIDTH-1:0] word_key;
  logic                 busy_q, busy_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 tok_vld_q;
  logic [KEY_WIDTH-1:0] tok_key_q;

  agps_pkg::tok_ctrl_t  ctrl_chain [TABLE_DEPTH+1];
  logic [KEY_WIDTH-1:0] key_chain  [TABLE_DEPTH+1];
  logic [IdxW-1:0]      idx_chain  [TABLE_DEPTH+1];
  agps_pkg::tok_ctrl_t  res_ctrl;

  assign accept      = start_i && !busy_o;
  assign accept_last = accept && last_of_word_i;

  agps_sig_acc #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_sig_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .letter_i    (letter_i),
    .no_letter_i (no_letter_i),
    .last_i      (last_of_word_i),
    .key_o       (word_key)
  );

  always_ff @(posedge clk_i) begin
    if (accept_last) begin
      tok_key_q <= word_key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= accept_last;
    end
  end

  assign ctrl_chain[0] = '{vld: tok_vld_q, found: 1'b0, is_new: 1'b0};
  assign key_chain[0]  = tok_key_q;
  assign idx_chain[0]  = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    agps_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .IDX_W     (IdxW),
      .CNT_W     (CntW),
      .CELL_IDX  (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_chain[g]),
      .key_i   (key_chain[g]),
      .idx_i   (idx_chain[g]),
      .count_i (count_q),
      .ctrl_o  (ctrl_chain[g+1]),
      .key_o   (key_chain[g+1]),
      .idx_o   (idx_chain[g+1])
    );
  end

  assign res_ctrl = ctrl_chain[TABLE_DEPTH];

  always_comb begin
    count_d = count_q;
    if (res_ctrl.vld && res_ctrl.is_new) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (accept_last) begin
      busy_d = 1'b1;
    end else if (res_ctrl.vld) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q  <= busy_d;
      count_q <= count_d;
    end
  end

  assign busy_o         = busy_q && !res_ctrl.vld;
  assign result_valid_o = res_ctrl.vld;
  assign new_group_o    = res_ctrl.is_new;
  assign table_full_o   = !res_ctrl.found;
  assign group_index_o  = res_ctrl.found ?
                          agps_pkg::GROUP_INDEX_W'(idx_chain[TABLE_DEPTH]) : '0;

endmodule
`default_nettype wire

### design/agps_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// agps_checker
// Port-level checks on the grouper: result strobe spacing, busy behaviour
// around word ends and consistency of the result flags.
// ----------------------------------------------------------------------------
module agps_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                start_i,
  input wire logic                                last_of_word_i,
  input wire logic                                busy_o,
  input wire logic                                result_valid_o,
  input wire logic [agps_pkg::GROUP_INDEX_W-1:0]  group_index_o,
  input wire logic                                new_group_o,
  input wire logic                                table_full_o
);

  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(new_group_o && table_full_o))
    else $error("new_group and table_full both set");

  a_full_index_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && table_full_o) |-> (group_index_o == '0))
    else $error("table_full with non-zero group index");

  a_word_end_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_of_word_i) |=> (busy_o && !result_valid_o))
    else $error("word end did not raise busy");

  a_letter_no_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !last_of_word_i && !result_valid_o) |=> !busy_o)
    else $error("plain letter raised busy");

  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

endmodule

bind anagram_group_prime_signature_core agps_checker u_agps_checker (.*);
`default_nettype wire
